### rtl/mi4_pkg.sv
// package for the 4x4 matrix inverse block
// shared widths and defaults; no dependencies
package mi4_pkg;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int ELEM_W = 32;
  localparam int IDX_W = 4;
  localparam int NUM_ELEM = 16;
  localparam int TRIP_W = 3 * ELEM_W;
  localparam int COF_W = TRIP_W + 3;
  localparam int DET_W = COF_W + ELEM_W + 2;
  localparam int NUM_W = COF_W + 2 * 24 + 2;
endpackage

### rtl/mi4_divider.sv
// restoring divider: magnitude quotient of num by den, one bit per cycle
// depends on mi4_pkg
module mi4_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [mi4_pkg::NUM_W-1:0]   num,
  input  logic [mi4_pkg::DET_W:0]     den,
  output logic                        done,
  output logic [mi4_pkg::NUM_W-1:0]   quo
);
  localparam int CW = $clog2(mi4_pkg::NUM_W + 1);
  logic [mi4_pkg::NUM_W-1:0] nsh;
  logic [mi4_pkg::DET_W+1:0] rem;
  logic [mi4_pkg::DET_W+1:0] trial;
  logic [CW-1:0] cnt;
  logic run;

  assign trial = {rem[mi4_pkg::DET_W:0], nsh[mi4_pkg::NUM_W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (go) begin
      run <= 1'b1;
      nsh <= num;
      rem <= '0;
      quo <= '0;
      cnt <= CW'(mi4_pkg::NUM_W);
    end else if (run) begin
      nsh <= nsh << 1;
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[mi4_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[mi4_pkg::NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

### rtl/matrix_inverse_4x4.sv
// 4x4 matrix inverse by cofactors, top level
// depends on mi4_pkg and mi4_divider
//
// usage: present element_index/element_value with start while busy is low;
// the element is written to the matrix memory. with compute_now set, the
// block then goes busy and inverts the stored matrix.
// each cofactor is built from six triple products read from memory, one
// product term at a time (three reads, a 32x32 multiply, a 64x32 multiply
// split into low and high partial products that are summed, accumulate),
// for all sixteen cofactors in turn; the determinant along row 0 then adds
// 33x32 partial products.
// each output element then takes one serial division, and the next division
// starts only after the previous result is out; busy stays high from a compute
// transaction until the last result, and load transactions leave busy low.
// results come out one per strobe with result_index, result_value, singular
// and last; the receiver cannot stall, so strobe is a single-cycle pulse.
// a singular matrix gives one result with singular set and value zero.
// reset is synchronous and clears control state only; the matrix memory
// holds nothing meaningful until written.
module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [mi4_pkg::IDX_W-1:0]          element_index,
  input  logic signed [mi4_pkg::ELEM_W-1:0]  element_value,
  input  logic                               compute_now,
  output logic                               strobe,
  output logic [mi4_pkg::IDX_W-1:0]          result_index,
  output logic signed [mi4_pkg::ELEM_W-1:0]  result_value,
  output logic                               singular,
  output logic                               last
);
  localparam int EW = mi4_pkg::ELEM_W;
  localparam int CW = mi4_pkg::COF_W;
  localparam int DW = mi4_pkg::DET_W;
  localparam int NW = mi4_pkg::NUM_W;
  localparam int TW = mi4_pkg::TRIP_W;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_M1, S_M2, S_M3, S_M4, S_ACC, S_DRD, S_DMUL,
    S_DPP, S_DACC, S_DIV, S_DWAIT, S_OUT, S_SING
  } state_t;
  state_t state;

  logic [EW-1:0] mem [mi4_pkg::NUM_ELEM];
  logic [EW-1:0] rdata;
  logic [mi4_pkg::IDX_W-1:0] raddr;
  logic [mi4_pkg::IDX_W-1:0] cof;
  logic [2:0] perm;
  logic signed [EW-1:0] a0, a1;
  logic signed [2*EW-1:0] p1;
  logic signed [2*EW:0] plo;
  logic signed [2*EW-1:0] phi;
  logic signed [mi4_pkg::TRIP_W-1:0] p2;
  logic signed [CW-1:0] acc;
  logic signed [CW-1:0] adj [mi4_pkg::NUM_ELEM];
  logic signed [DW-1:0] det;
  logic signed [2*EW:0] pp;
  logic [1:0] k;
  logic [1:0] dpart;
  logic div_go, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW:0] div_den;
  logic qneg;

  logic [1:0] r, c, sr, sc, rr0, rr1, rr2, cc0, cc1, cc2, pc0, pc1, pc2;
  logic psub;

  function automatic logic [1:0] pick(input logic [1:0] skip, input logic [1:0] n);
    logic [1:0] v;
    v = n;
    if (n >= skip) v = n + 2'd1;
    return v;
  endfunction

  always_comb begin
    r = cof[3:2];
    c = cof[1:0];
    sr = c;
    sc = r;
    rr0 = pick(sr, 2'd0);
    rr1 = pick(sr, 2'd1);
    rr2 = pick(sr, 2'd2);
    unique case (perm)
      3'd0: begin pc0 = 2'd0; pc1 = 2'd1; pc2 = 2'd2; psub = 1'b0; end
      3'd1: begin pc0 = 2'd0; pc1 = 2'd2; pc2 = 2'd1; psub = 1'b1; end
      3'd2: begin pc0 = 2'd1; pc1 = 2'd0; pc2 = 2'd2; psub = 1'b1; end
      3'd3: begin pc0 = 2'd1; pc1 = 2'd2; pc2 = 2'd0; psub = 1'b0; end
      3'd4: begin pc0 = 2'd2; pc1 = 2'd0; pc2 = 2'd1; psub = 1'b0; end
      default: begin pc0 = 2'd2; pc1 = 2'd1; pc2 = 2'd0; psub = 1'b1; end
    endcase
    cc0 = pick(sc, pc0);
    cc1 = pick(sc, pc1);
    cc2 = pick(sc, pc2);
    if (r[0] ^ c[0]) psub = ~psub;
  end

  always_comb begin
    raddr = {rr0, cc0};
    unique case (state)
      S_RD1: raddr = {rr1, cc1};
      S_RD2: raddr = {rr2, cc2};
      S_DRD: raddr = {2'd0, k};
      default: raddr = {rr0, cc0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) mem[element_index] <= element_value;
    rdata <= mem[raddr];
  end

  logic signed [CW-1:0] adjsel;
  logic signed [CW-1:0] adjd;
  logic signed [EW:0] dlimb;
  logic signed [DW-1:0] dterm;
  logic [DW-1:0] dmag;
  logic [CW-1:0] amag;
  logic signed [DW-1:0] det_next;
  assign adjsel = adj[cof];
  assign adjd = adj[{k, 2'd0}];
  assign dmag = det[DW-1] ? DW'(-det) : DW'(det);
  assign amag = adjsel[CW-1] ? CW'(-adjsel) : CW'(adjsel);
  assign det_next = det + dterm;

  // 32-bit slices of the row 0 cofactor, top slice sign extended
  always_comb begin
    unique case (dpart)
      2'd0: begin
        dlimb = {1'b0, adjd[EW-1:0]};
        dterm = DW'(pp);
      end
      2'd1: begin
        dlimb = {1'b0, adjd[2*EW-1:EW]};
        dterm = DW'(pp) <<< EW;
      end
      2'd2: begin
        dlimb = {1'b0, adjd[3*EW-1:2*EW]};
        dterm = DW'(pp) <<< (2*EW);
      end
      default: begin
        dlimb = {{(4*EW+1-CW){adjd[CW-1]}}, adjd[CW-1:3*EW]};
        dterm = DW'(pp) <<< (3*EW);
      end
    endcase
  end

  mi4_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start && compute_now) begin
          busy <= 1'b1;
          cof <= '0;
          perm <= '0;
          acc <= '0;
          state <= S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin a0 <= rdata; state <= S_RD2; end
        S_RD2: begin a1 <= rdata; state <= S_M1; end
        S_M1: begin p1 <= a0 * a1; a0 <= rdata; state <= S_M2; end
        S_M2: begin plo <= $signed({1'b0, p1[EW-1:0]}) * a0; state <= S_M3; end
        S_M3: begin phi <= $signed(p1[2*EW-1:EW]) * a0; state <= S_M4; end
        S_M4: begin p2 <= {phi, {EW{1'b0}}} + TW'(plo); state <= S_ACC; end
        S_ACC: begin
          if (psub) acc <= acc - CW'(p2);
          else acc <= acc + CW'(p2);
          if (perm == 3'd5) begin
            adj[cof] <= psub ? acc - CW'(p2) : acc + CW'(p2);
            acc <= '0;
            perm <= '0;
            cof <= cof + 1'b1;
            if (cof == 4'd15) begin
              k <= '0;
              det <= '0;
              state <= S_DRD;
            end else state <= S_RD0;
          end else begin
            perm <= perm + 1'b1;
            state <= S_RD0;
          end
        end
        S_DRD: state <= S_DMUL;
        S_DMUL: begin
          a1 <= rdata;
          dpart <= '0;
          state <= S_DPP;
        end
        S_DPP: begin
          pp <= dlimb * a1;
          state <= S_DACC;
        end
        S_DACC: begin
          det <= det_next;
          cof <= '0;
          if (dpart == 2'd3) begin
            k <= k + 1'b1;
            if (k == 2'd3) state <= (det_next == '0) ? S_SING : S_DIV;
            else state <= S_DRD;
          end else begin
            dpart <= dpart + 1'b1;
            state <= S_DPP;
          end
        end
        S_SING: begin
          strobe <= 1'b1;
          result_index <= '0;
          result_value <= '0;
          singular <= 1'b1;
          last <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        S_DIV: begin
          div_num <= (NW'(amag) << (2 * FRAC_BITS + 1)) + NW'(dmag);
          div_den <= {dmag, 1'b0};
          qneg <= adjsel[CW-1] ^ det[DW-1];
          div_go <= 1'b1;
          state <= S_DWAIT;
        end
        S_DWAIT: if (div_done) state <= S_OUT;
        S_OUT: begin
          strobe <= 1'b1;
          result_index <= cof;
          singular <= 1'b0;
          last <= (cof == 4'd15);
          if (qneg) begin
            result_value <= (div_quo >= NW'(33'h080000000)) ?
              EW'(32'h80000000) : EW'(-div_quo[EW-1:0]);
          end else begin
            result_value <= (div_quo > NW'(32'h7FFFFFFF)) ?
              EW'(32'h7FFFFFFF) : div_quo[EW-1:0];
          end
          cof <= cof + 1'b1;
          if (cof == 4'd15) begin
            busy <= 1'b0;
            state <= S_IDLE;
          end else state <= S_DIV;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
